@@ rtl/core/bol_pkg.sv @@
package bol_pkg;

	localparam int DEPTH     = 16;
	localparam int WORD_BITS = 32;

	localparam int POS_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CMD_W  = 3;
	localparam int IDX_W  = 5;
	localparam int VAL_W  = 32;
	localparam int RDV_W  = 32;
	localparam int FND_W  = 5;
	localparam int REM_W  = 5;
	localparam int OCNT_W = 5;
	localparam int STAT_W = 2;
	localparam int CMP_W  = (IDX_W > CNT_W) ? IDX_W : CNT_W;

	localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_DROP    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_PURGE   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_FIND    = 3'd5;
	localparam logic [CMD_W-1:0] CMD_READ    = 3'd6;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

	localparam logic signed [FND_W-1:0] FOUND_NONE = 5'sh1F;

	typedef enum logic [2:0] {
		CELL_HOLD   = 3'd0,
		CELL_APPEND = 3'd1,
		CELL_INSERT = 3'd2,
		CELL_DELETE = 3'd3,
		CELL_PURGE  = 3'd4
	} cell_op_t;

	typedef struct packed {
		cell_op_t               op;
		logic [IDX_W-1:0]       index;
		logic [CNT_W-1:0]       count;
		logic [WORD_BITS-1:0]   value;
	} cell_ctrl_t;

endpackage

@@ rtl/core/bol_req_if.sv @@
interface bol_req_if;
	logic                         valid;
	logic                         ready;
	logic [bol_pkg::CMD_W-1:0]    cmd;
	logic [bol_pkg::IDX_W-1:0]    index;
	logic [bol_pkg::VAL_W-1:0]    value;

	modport source (output valid, output cmd, output index, output value, input ready);
	modport sink   (input valid, input cmd, input index, input value, output ready);
endinterface

@@ rtl/core/bol_rsp_if.sv @@
interface bol_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [bol_pkg::RDV_W-1:0]           read_value;
	logic signed [bol_pkg::FND_W-1:0]    found_index;
	logic [bol_pkg::REM_W-1:0]           removed_count;
	logic [bol_pkg::OCNT_W-1:0]          count;
	logic [bol_pkg::STAT_W-1:0]          status;

	modport source (output valid, output read_value, output found_index, output removed_count,
		output count, output status, input ready);
	modport sink   (input valid, input read_value, input found_index, input removed_count,
		input count, input status, output ready);
endinterface

@@ rtl/core/bol_cell.sv @@
module bol_cell (
	input  logic                           clk,
	input  logic [bol_pkg::POS_W-1:0]      pos,
	input  bol_pkg::cell_ctrl_t            ctrl,
	input  logic [bol_pkg::WORD_BITS-1:0]  left,
	input  logic [bol_pkg::WORD_BITS-1:0]  right,
	input  logic                           hit_in,
	output logic [bol_pkg::WORD_BITS-1:0]  entry,
	output logic                           hit_out,
	output logic                           first,
	output logic [bol_pkg::WORD_BITS-1:0]  rd_data
);

	logic [bol_pkg::WORD_BITS-1:0] entry_q;
	logic [bol_pkg::WORD_BITS-1:0] entry_d;
	logic [bol_pkg::CMP_W-1:0]     p;
	logic [bol_pkg::CMP_W-1:0]     i;
	logic [bol_pkg::CMP_W-1:0]     c;
	logic                          live;
	logic                          match;

	assign p       = bol_pkg::CMP_W'(pos);
	assign i       = bol_pkg::CMP_W'(ctrl.index);
	assign c       = bol_pkg::CMP_W'(ctrl.count);
	assign live    = p < c;
	assign match   = live && (entry_q == ctrl.value);
	assign hit_out = hit_in | match;
	assign first   = match & ~hit_in;
	assign rd_data = (p == i) ? entry_q : '0;
	assign entry   = entry_q;

	always_comb begin
		entry_d = entry_q;
		case (ctrl.op)
			bol_pkg::CELL_APPEND: begin
				if (p == c) begin
					entry_d = ctrl.value;
				end
			end
			bol_pkg::CELL_INSERT: begin
				if (p == i) begin
					entry_d = ctrl.value;
				end else if (p > i && p <= c) begin
					entry_d = left;
				end
			end
			bol_pkg::CELL_DELETE: begin
				if (p >= i) begin
					entry_d = right;
				end
			end
			bol_pkg::CELL_PURGE: begin
				if (hit_out) begin
					entry_d = right;
				end
			end
			default: begin
				entry_d = entry_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule

@@ rtl/core/bounded_ordered_list.sv @@
// Flow: an accepted request moves to S_EXEC, and its result and result valid are
//   registered as it leaves S_EXEC; delete all matches first removes one entry per cycle.
// Requests are taken only in S_IDLE, so a new request is not accepted until the last
//   one finishes; a waiting result holds execute only.
// Reset: arst_n clears the entry count, the control state and the result valid;
//   entry storage is not cleared.
module bounded_ordered_list (
	input  logic      clk,
	input  logic      arst_n,
	bol_req_if.sink   req,
	bol_rsp_if.source rsp
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	localparam int D = bol_pkg::DEPTH;
	localparam int W = bol_pkg::WORD_BITS;

	state_t                         state_q;
	logic [bol_pkg::CMD_W-1:0]      cmd_q;
	logic [bol_pkg::IDX_W-1:0]      index_q;
	logic [W-1:0]                   value_q;
	logic [bol_pkg::CNT_W-1:0]      count_q;
	logic [bol_pkg::CNT_W-1:0]      removed_q;

	logic                           rsp_valid_q;
	logic [bol_pkg::RDV_W-1:0]      read_value_q;
	logic signed [bol_pkg::FND_W-1:0] found_index_q;
	logic [bol_pkg::REM_W-1:0]      removed_count_q;
	logic [bol_pkg::OCNT_W-1:0]     count_out_q;
	logic [bol_pkg::STAT_W-1:0]     status_q;

	bol_pkg::cell_ctrl_t            ctrl;
	logic [W-1:0]                   entry_w [D];
	logic [W-1:0]                   rd_w    [D];
	logic [D:0]                     hit_w;
	logic [D-1:0]                   first_w;

	logic [W-1:0]                   rd_all;
	logic [bol_pkg::POS_W-1:0]      found_pos;

	logic                           accept;
	logic                           out_free;
	logic                           finish;
	logic [bol_pkg::CNT_W-1:0]      count_d;
	logic [bol_pkg::CNT_W-1:0]      removed_d;
	logic [bol_pkg::CNT_W-1:0]      res_removed;
	logic [W-1:0]                   res_rd;
	logic signed [bol_pkg::FND_W-1:0] res_found;
	logic [bol_pkg::STAT_W-1:0]     res_status;
	logic                           full;
	logic                           empty;
	logic [bol_pkg::CMP_W-1:0]      idx_c;
	logic [bol_pkg::CMP_W-1:0]      cnt_c;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;

	assign rsp.valid         = rsp_valid_q;
	assign rsp.read_value    = read_value_q;
	assign rsp.found_index   = found_index_q;
	assign rsp.removed_count = removed_count_q;
	assign rsp.count         = count_out_q;
	assign rsp.status        = status_q;

	assign hit_w[0] = 1'b0;

	for (genvar g = 0; g < D; g++) begin : g_cell
		logic [W-1:0] left_w;
		logic [W-1:0] right_w;
		if (g == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid
			assign left_w = entry_w[g-1];
		end
		if (g == D - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_next
			assign right_w = entry_w[g+1];
		end
		bol_cell u_cell (
			.clk     (clk),
			.pos     (bol_pkg::POS_W'(g)),
			.ctrl    (ctrl),
			.left    (left_w),
			.right   (right_w),
			.hit_in  (hit_w[g]),
			.entry   (entry_w[g]),
			.hit_out (hit_w[g+1]),
			.first   (first_w[g]),
			.rd_data (rd_w[g])
		);
	end

	always_comb begin
		rd_all    = '0;
		found_pos = '0;
		for (int k = 0; k < D; k++) begin
			rd_all = rd_all | rd_w[k];
			if (first_w[k]) begin
				found_pos = found_pos | bol_pkg::POS_W'(k);
			end
		end
	end

	assign full  = (count_q == bol_pkg::CNT_W'(D));
	assign empty = (count_q == '0);
	assign idx_c = bol_pkg::CMP_W'(index_q);
	assign cnt_c = bol_pkg::CMP_W'(count_q);

	always_comb begin
		ctrl.op     = bol_pkg::CELL_HOLD;
		ctrl.index  = index_q;
		ctrl.count  = count_q;
		ctrl.value  = value_q;
		finish      = 1'b0;
		count_d     = count_q;
		removed_d   = removed_q;
		res_removed = '0;
		res_rd      = '0;
		res_found   = bol_pkg::FOUND_NONE;
		res_status  = bol_pkg::ST_OK;
		if (state_q == S_EXEC) begin
			if (cmd_q == bol_pkg::CMD_PURGE) begin
				if (hit_w[D]) begin
					ctrl.op   = bol_pkg::CELL_PURGE;
					count_d   = count_q - 1'b1;
					removed_d = removed_q + 1'b1;
				end else if (out_free) begin
					finish      = 1'b1;
					res_removed = removed_q;
				end
			end else if (out_free) begin
				finish = 1'b1;
				case (cmd_q)
					bol_pkg::CMD_APPEND: begin
						if (full) begin
							res_status = bol_pkg::ST_FULL;
						end else begin
							ctrl.op = bol_pkg::CELL_APPEND;
							count_d = count_q + 1'b1;
						end
					end
					bol_pkg::CMD_INSERT: begin
						if (idx_c > cnt_c) begin
							res_status = bol_pkg::ST_RANGE;
						end else if (full) begin
							res_status = bol_pkg::ST_FULL;
						end else begin
							ctrl.op = bol_pkg::CELL_INSERT;
							count_d = count_q + 1'b1;
						end
					end
					bol_pkg::CMD_DROP: begin
						if (empty) begin
							res_status = bol_pkg::ST_EMPTY;
						end else begin
							count_d     = count_q - 1'b1;
							res_removed = bol_pkg::CNT_W'(1);
						end
					end
					bol_pkg::CMD_DELETE: begin
						if (empty) begin
							res_status = bol_pkg::ST_EMPTY;
						end else if (idx_c >= cnt_c) begin
							res_status = bol_pkg::ST_RANGE;
						end else begin
							ctrl.op     = bol_pkg::CELL_DELETE;
							count_d     = count_q - 1'b1;
							res_removed = bol_pkg::CNT_W'(1);
						end
					end
					bol_pkg::CMD_FIND: begin
						if (hit_w[D]) begin
							res_found = bol_pkg::FND_W'(found_pos);
						end
					end
					bol_pkg::CMD_READ: begin
						if (idx_c >= cnt_c) begin
							res_status = bol_pkg::ST_RANGE;
						end else begin
							res_rd = rd_all;
						end
					end
					default: begin
						res_status = bol_pkg::ST_OK;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			removed_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q   <= count_d;
			removed_q <= accept ? '0 : removed_d;
			if (accept) begin
				state_q <= S_EXEC;
			end else if (finish) begin
				state_q <= S_IDLE;
			end
			if (finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= req.cmd;
			index_q <= req.index;
			value_q <= W'(req.value);
		end
		if (finish) begin
			read_value_q    <= bol_pkg::RDV_W'(res_rd);
			found_index_q   <= res_found;
			removed_count_q <= bol_pkg::REM_W'(res_removed);
			count_out_q     <= bol_pkg::OCNT_W'(count_d);
			status_q        <= res_status;
		end
	end

endmodule

@@ rtl/core/bol_checker.sv @@
module bol_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                rsp_valid,
	input logic                                rsp_ready,
	input logic [bol_pkg::RDV_W-1:0]           rsp_read_value,
	input logic signed [bol_pkg::FND_W-1:0]    rsp_found_index,
	input logic [bol_pkg::REM_W-1:0]           rsp_removed_count,
	input logic [bol_pkg::OCNT_W-1:0]          rsp_count,
	input logic [bol_pkg::STAT_W-1:0]          rsp_status
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value)
			&& $stable(rsp_found_index) && $stable(rsp_removed_count)
			&& $stable(rsp_count) && $stable(rsp_status))
		else $error("result changed while stalled");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_count <= bol_pkg::OCNT_W'(bol_pkg::DEPTH))
		else $error("count above depth");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == bol_pkg::ST_FULL
			|-> rsp_count == bol_pkg::OCNT_W'(bol_pkg::DEPTH) && rsp_removed_count == '0)
		else $error("full status with room left");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == bol_pkg::ST_EMPTY
			|-> rsp_count == '0 && rsp_removed_count == '0 && rsp_read_value == '0)
		else $error("empty status on non-empty list");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_found_index != bol_pkg::FOUND_NONE
			|-> rsp_status == bol_pkg::ST_OK && rsp_removed_count == '0
				&& rsp_found_index < $signed({1'b0, rsp_count}))
		else $error("found position outside list");

endmodule

bind bounded_ordered_list bol_checker u_bol_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_read_value    (rsp.read_value),
	.rsp_found_index   (rsp.found_index),
	.rsp_removed_count (rsp.removed_count),
	.rsp_count         (rsp.count),
	.rsp_status        (rsp.status)
);

@@ bench/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [bol_pkg::CMD_W-1:0] CMD_UNUSED = 3'd7;
	localparam int STALL_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [bol_pkg::RDV_W-1:0]        read_value;
		logic signed [bol_pkg::FND_W-1:0] found_index;
		logic [bol_pkg::REM_W-1:0]        removed_count;
		logic [bol_pkg::OCNT_W-1:0]       count;
		logic [bol_pkg::STAT_W-1:0]       status;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n;

	bol_req_if req_ch();
	bol_rsp_if rsp_ch();

	bounded_ordered_list i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	logic [bol_pkg::WORD_BITS-1:0] list_mem [bol_pkg::DEPTH];
	int                            list_len = 0;
	logic [bol_pkg::VAL_W-1:0]     word_pool [4];
	outcome_t                      expected_results [$];
	int                            failures = 0;
	int                            stalled_cycles = 0;
	bit                            steady_flow = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic outcome_t apply_request(logic [bol_pkg::CMD_W-1:0] op,
		logic [bol_pkg::IDX_W-1:0] pos, logic [bol_pkg::VAL_W-1:0] word_in);
		outcome_t                      res;
		logic [bol_pkg::WORD_BITS-1:0] word;
		int                            kept;
		int                            j;
		word = word_in[bol_pkg::WORD_BITS-1:0];
		res.read_value = '0;
		res.found_index = bol_pkg::FOUND_NONE;
		res.removed_count = '0;
		res.status = bol_pkg::ST_OK;
		case (op)
			bol_pkg::CMD_APPEND: begin
				if (list_len >= bol_pkg::DEPTH) begin
					res.status = bol_pkg::ST_FULL;
				end else begin
					list_mem[list_len] = word;
					list_len++;
				end
			end
			bol_pkg::CMD_INSERT: begin
				if (pos > list_len) begin
					res.status = bol_pkg::ST_RANGE;
				end else if (list_len >= bol_pkg::DEPTH) begin
					res.status = bol_pkg::ST_FULL;
				end else begin
					for (j = list_len; j > pos; j--)
						list_mem[j] = list_mem[j-1];
					list_mem[pos] = word;
					list_len++;
				end
			end
			bol_pkg::CMD_DROP: begin
				if (list_len == 0) begin
					res.status = bol_pkg::ST_EMPTY;
				end else begin
					list_len--;
					res.removed_count = 1;
				end
			end
			bol_pkg::CMD_DELETE: begin
				if (list_len == 0) begin
					res.status = bol_pkg::ST_EMPTY;
				end else if (pos >= list_len) begin
					res.status = bol_pkg::ST_RANGE;
				end else begin
					for (j = pos; j < list_len - 1; j++)
						list_mem[j] = list_mem[j+1];
					list_len--;
					res.removed_count = 1;
				end
			end
			bol_pkg::CMD_PURGE: begin
				kept = 0;
				for (j = 0; j < list_len; j++) begin
					if (list_mem[j] == word) begin
						res.removed_count++;
					end else begin
						list_mem[kept] = list_mem[j];
						kept++;
					end
				end
				list_len = kept;
			end
			bol_pkg::CMD_FIND: begin
				for (j = list_len - 1; j >= 0; j--)
					if (list_mem[j] == word)
						res.found_index = bol_pkg::FND_W'(j);
			end
			bol_pkg::CMD_READ: begin
				if (pos >= list_len)
					res.status = bol_pkg::ST_RANGE;
				else
					res.read_value = bol_pkg::RDV_W'(list_mem[pos]);
			end
			default: ;
		endcase
		res.count = bol_pkg::OCNT_W'(list_len);
		return res;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			failures++;
		end
	endfunction

	task automatic send_request(input logic [bol_pkg::CMD_W-1:0] op,
		input logic [bol_pkg::IDX_W-1:0] pos, input logic [bol_pkg::VAL_W-1:0] word);
		int gap;
		req_ch.valid <= 1'b1;
		req_ch.cmd   <= op;
		req_ch.index <= pos;
		req_ch.value <= word;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		expected_results.insert(expected_results.size(), apply_request(op, pos, word));
		gap = steady_flow ? 0 : gap_len();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [bol_pkg::CMD_W-1:0] pick_command(bit growing);
		int r;
		r = $urandom_range(0, 99);
		if (r < (growing ? 30 : 10)) return bol_pkg::CMD_APPEND;
		if (r < (growing ? 55 : 20)) return bol_pkg::CMD_INSERT;
		if (r < (growing ? 60 : 35)) return bol_pkg::CMD_DROP;
		if (r < (growing ? 65 : 55)) return bol_pkg::CMD_DELETE;
		if (r < (growing ? 70 : 67)) return bol_pkg::CMD_PURGE;
		if (r < (growing ? 84 : 82)) return bol_pkg::CMD_FIND;
		if (r < 98) return bol_pkg::CMD_READ;
		return CMD_UNUSED;
	endfunction

	function automatic logic [bol_pkg::IDX_W-1:0] pick_index();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75) return bol_pkg::IDX_W'($urandom_range(0, list_len));
		if (r < 93) return bol_pkg::IDX_W'($urandom_range(0, bol_pkg::DEPTH));
		return bol_pkg::IDX_W'($urandom_range(0, (1 << bol_pkg::IDX_W) - 1));
	endfunction

	function automatic logic [bol_pkg::VAL_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60 && list_len > 0 && r >= 40)
			return bol_pkg::VAL_W'(list_mem[$urandom_range(0, list_len - 1)]);
		if (r < 60) return word_pool[$urandom_range(0, 3)];
		if (r < 70) return $urandom_range(0, 1) ? '1 : '0;
		return $urandom;
	endfunction

	task automatic test_empty_list();
		send_request(bol_pkg::CMD_DROP,   '0, '0);
		send_request(bol_pkg::CMD_DELETE, '0, '0);
		send_request(bol_pkg::CMD_READ,   '0, '0);
		send_request(bol_pkg::CMD_FIND,   '0, '1);
		send_request(bol_pkg::CMD_PURGE,  '0, '1);
		send_request(bol_pkg::CMD_INSERT, 5'd1, 32'h1234_5678);
		send_request(CMD_UNUSED, '1, '1);
	endtask

	task automatic test_full_list();
		int k;
		send_request(bol_pkg::CMD_INSERT, '0, '0);
		send_request(bol_pkg::CMD_APPEND, '1, '1);
		for (k = 2; k < bol_pkg::DEPTH; k++)
			send_request(bol_pkg::CMD_APPEND, '0,
				(k % 2 == 0) ? 32'h5A5A_5A5A : bol_pkg::VAL_W'(k));
		send_request(bol_pkg::CMD_APPEND, '0, 32'hDEAD_BEEF);
		send_request(bol_pkg::CMD_INSERT, 5'd17, 32'hDEAD_BEEF);
		send_request(bol_pkg::CMD_INSERT, bol_pkg::IDX_W'(bol_pkg::DEPTH), 32'hDEAD_BEEF);
		send_request(bol_pkg::CMD_READ,   bol_pkg::IDX_W'(bol_pkg::DEPTH), '0);
		send_request(bol_pkg::CMD_DELETE, bol_pkg::IDX_W'(bol_pkg::DEPTH), '0);
		send_request(bol_pkg::CMD_PURGE,  '0, 32'h5A5A_5A5A);
	endtask

	task automatic test_random_mix(input int n_items);
		int k;
		bit growing;
		for (k = 0; k < 4; k++)
			word_pool[k] = $urandom;
		for (k = 0; k < n_items; k++) begin
			if (k % 40 == 0)
				growing = $urandom_range(0, 1);
			send_request(pick_command(growing), pick_index(), pick_value());
		end
	endtask

	task automatic test_back_to_back(input int n_items);
		steady_flow = 1'b1;
		test_random_mix(n_items);
		steady_flow = 1'b0;
	endtask

	initial begin
		int gap;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = steady_flow ? 0 : gap_len();
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1));
		end
	end

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (expected_results.size() == 0) begin
				$error("result with no request pending");
				failures++;
			end else begin
				want = expected_results.pop_front();
				check_field("read_value", want.read_value, rsp_ch.read_value);
				check_field("found_index", $signed(want.found_index), $signed(rsp_ch.found_index));
				check_field("removed_count", want.removed_count, rsp_ch.removed_count);
				check_field("count", want.count, rsp_ch.count);
				check_field("status", want.status, rsp_ch.status);
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
			(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
			stalled_cycles <= 0;
		else
			stalled_cycles <= stalled_cycles + 1;
		if (stalled_cycles >= STALL_LIMIT) begin
			$display("bounded_ordered_list test failed");
			$finish;
		end
	end

	initial begin
		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.cmd   = bol_pkg::CMD_APPEND;
		req_ch.index = '0;
		req_ch.value = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_full_list();
		test_random_mix(470);
		test_back_to_back(150);

		req_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("bounded_ordered_list test passed");
		else
			$display("bounded_ordered_list test failed");
		$finish;
	end
endmodule
